/* sv/att_pkg.sv */
`default_nettype none
package att_pkg;

   localparam int MAG_W = 16;
   localparam int SQ_W = 31;
   localparam int SUM_W = 32;
   localparam int FRAC_BITS = 14;
   localparam int RAD_W = 60;
   localparam int ROOT_W = 30;
   localparam int VEC_W = 36;
   localparam int ACC_W = 24;
   localparam int ANGLE_W = 15;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam logic signed [ANGLE_W:0] QUARTER_TURN = 16'sd9000;

   // Travels beside the datapath of one angle.
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic             num_zero;
      logic             den_zero;
   } side_type;

   // atan(2^-i) in 1/256 of a hundredth of a degree.
   function automatic logic signed [ACC_W-1:0] atan_step(input int i);
      logic signed [ACC_W-1:0] v;
      case (i)
         0: v = 24'sd1152000;
         1: v = 24'sd680065;
         2: v = 24'sd359328;
         3: v = 24'sd182400;
         4: v = 24'sd91554;
         5: v = 24'sd45822;
         6: v = 24'sd22916;
         7: v = 24'sd11459;
         8: v = 24'sd5730;
         9: v = 24'sd2865;
         10: v = 24'sd1432;
         11: v = 24'sd716;
         12: v = 24'sd358;
         13: v = 24'sd179;
         14: v = 24'sd90;
         15: v = 24'sd45;
         16: v = 24'sd22;
         17: v = 24'sd11;
         18: v = 24'sd6;
         19: v = 24'sd3;
         20: v = 24'sd1;
         21: v = 24'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* sv/att_if.sv */
`default_nettype none
interface att_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface att_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] pitch_angle;
   logic signed [14:0] roll_angle;
   modport source (output valid, pitch_angle, roll_angle, input ready);
   modport sink (input valid, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

/* sv/att_sqrt_cell.sv */
`default_nettype none
// One result bit of a restoring square root.
module att_sqrt_cell #(
   parameter int BIT_IDX = 0
) (
   input  wire logic                           clock,
   input  wire logic                           enable,
   input  wire logic [att_pkg::RAD_W-1:0]      rem_in,
   input  wire logic [att_pkg::ROOT_W-1:0]     root_in,
   input  wire att_pkg::side_type              side_in,
   output logic [att_pkg::RAD_W-1:0]           rem_out,
   output logic [att_pkg::ROOT_W-1:0]          root_out,
   output att_pkg::side_type                   side_out
);
   import att_pkg::*;

   logic [RAD_W-1:0]  trial;
   logic [RAD_W-1:0]  rem_in_c;
   logic [ROOT_W-1:0] root_in_c;
   logic [RAD_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   side_type          side_ff;

   always_comb begin
      trial = (RAD_W'(root_in) << (BIT_IDX + 1)) + (RAD_W'(1) << (2 * BIT_IDX));
      if (rem_in >= trial) begin
         rem_in_c = rem_in - trial;
         root_in_c = root_in | (ROOT_W'(1) << BIT_IDX);
      end else begin
         rem_in_c = rem_in;
         root_in_c = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_c;
         root_ff <= root_in_c;
         side_ff <= side_in;
      end
   end

   assign rem_out = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

/* sv/att_cordic_cell.sv */
`default_nettype none
// One vectoring micro-rotation.
module att_cordic_cell #(
   parameter int STEP_IDX = 0
) (
   input  wire logic                               clock,
   input  wire logic                               enable,
   input  wire logic signed [att_pkg::VEC_W-1:0]   a_in,
   input  wire logic signed [att_pkg::VEC_W-1:0]   b_in,
   input  wire logic signed [att_pkg::ACC_W-1:0]   acc_in,
   input  wire att_pkg::side_type                  side_in,
   output logic signed [att_pkg::VEC_W-1:0]        a_out,
   output logic signed [att_pkg::VEC_W-1:0]        b_out,
   output logic signed [att_pkg::ACC_W-1:0]        acc_out,
   output att_pkg::side_type                       side_out
);
   import att_pkg::*;

   logic signed [VEC_W-1:0] da;
   logic signed [VEC_W-1:0] db;
   logic signed [VEC_W-1:0] a_in_c;
   logic signed [VEC_W-1:0] b_in_c;
   logic signed [ACC_W-1:0] acc_in_c;
   logic signed [VEC_W-1:0] a_ff;
   logic signed [VEC_W-1:0] b_ff;
   logic signed [ACC_W-1:0] acc_ff;
   side_type                side_ff;

   always_comb begin
      da = b_in >>> STEP_IDX;
      db = a_in >>> STEP_IDX;
      if (b_in > 0) begin
         a_in_c = a_in + da;
         b_in_c = b_in - db;
         acc_in_c = acc_in + atan_step(STEP_IDX);
      end else begin
         a_in_c = a_in - da;
         b_in_c = b_in + db;
         acc_in_c = acc_in - atan_step(STEP_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff <= a_in_c;
         b_ff <= b_in_c;
         acc_ff <= acc_in_c;
         side_ff <= side_in;
      end
   end

   assign a_out = a_ff;
   assign b_out = b_ff;
   assign acc_out = acc_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

/* sv/accel_tilt_angles.sv */
// Tilt angles from a three-axis accelerometer.
// req_chan carries one sample word (accel_x, accel_y, accel_z, signed 16 bit);
// rsp_chan returns one word per sample: pitch_angle and roll_angle in signed
// hundredths of a degree, -9000..9000.
// Both channels move a word when valid and ready are high at a clock edge.
// Throughput: one word per cycle while rsp_chan does not stall.
// The datapath is a row of registered cells: a squaring stage, a sum stage,
// 30 square-root cells (one root bit each), CORDIC_STAGES rotation cells and
// an output register.
// When the receiver holds rsp_chan.ready low with a word waiting, the whole
// row freezes and req_chan.ready drops; words in flight are kept, none lost.
// Bubbles in the row are squeezed out only as the row advances.
// Reset (synchronous, active high) clears all valid flags; no clearing pass,
// the block takes a word in the first cycle after reset.
`default_nettype none
module accel_tilt_angles #(
   parameter int CORDIC_STAGES = att_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   att_req_if.sink   req_chan,
   att_rsp_if.source rsp_chan
);
   import att_pkg::*;

   localparam int NUM_STAGES = 2 + ROOT_W + CORDIC_STAGES + 1;

   // one valid flag per stage of the row
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic                  enable;

   assign enable = !vld_ff[NUM_STAGES-1] || rsp_chan.ready;
   assign req_chan.ready = enable;
   assign vld_in = {vld_ff[NUM_STAGES-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   // squaring stage
   logic [SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   side_type         sq_side_ff [2];
   side_type         sq_side_in [2];
   logic signed [2*MAG_W-1:0] px, py, pz;
   logic [MAG_W:0]   magx, magy;

   always_comb begin
      px = req_chan.accel_x * req_chan.accel_x;
      py = req_chan.accel_y * req_chan.accel_y;
      pz = req_chan.accel_z * req_chan.accel_z;
      magx = req_chan.accel_x[MAG_W-1] ? -{1'b1, req_chan.accel_x}
                                       : {1'b0, req_chan.accel_x};
      magy = req_chan.accel_y[MAG_W-1] ? -{1'b1, req_chan.accel_y}
                                       : {1'b0, req_chan.accel_y};
      sq_side_in[0].mag = magx[MAG_W-1:0];
      sq_side_in[0].neg = req_chan.accel_x[MAG_W-1];
      sq_side_in[0].num_zero = (req_chan.accel_x == '0);
      sq_side_in[0].den_zero = (req_chan.accel_y == '0) && (req_chan.accel_z == '0);
      sq_side_in[1].mag = magy[MAG_W-1:0];
      sq_side_in[1].neg = req_chan.accel_y[MAG_W-1];
      sq_side_in[1].num_zero = (req_chan.accel_y == '0);
      sq_side_in[1].den_zero = (req_chan.accel_x == '0) && (req_chan.accel_z == '0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sqx_ff <= px[SQ_W-1:0];
         sqy_ff <= py[SQ_W-1:0];
         sqz_ff <= pz[SQ_W-1:0];
         sq_side_ff <= sq_side_in;
      end
   end

   // sum stage: pitch uses y,z, roll uses x,z
   logic [SUM_W-1:0] sum_ff [2];
   side_type         sum_side_ff [2];

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff[0] <= SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
         sum_ff[1] <= SUM_W'(sqx_ff) + SUM_W'(sqz_ff);
         sum_side_ff <= sq_side_ff;
      end
   end

   // result stage
   logic signed [ANGLE_W-1:0] ang_ff [2];
   logic signed [ANGLE_W-1:0] ang_in [2];

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [RAD_W-1:0]        rem_w  [ROOT_W+1];
      logic [ROOT_W-1:0]       root_w [ROOT_W+1];
      side_type                sside_w [ROOT_W+1];
      logic signed [VEC_W-1:0] a_w [CORDIC_STAGES+1];
      logic signed [VEC_W-1:0] b_w [CORDIC_STAGES+1];
      logic signed [ACC_W-1:0] acc_w [CORDIC_STAGES+1];
      side_type                cside_w [CORDIC_STAGES+1];
      logic signed [ANGLE_W:0] rnd;
      logic signed [ANGLE_W:0] mag_ang;
      logic signed [ACC_W-1:0] acc_rnd;

      assign rem_w[0] = RAD_W'(sum_ff[ln]) << (2 * FRAC_BITS);
      assign root_w[0] = '0;
      assign sside_w[0] = sum_side_ff[ln];

      // highest root bit first
      for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
         att_sqrt_cell #(.BIT_IDX(ROOT_W - 1 - k)) u_cell (
            .clock    (clock),
            .enable   (enable),
            .rem_in   (rem_w[k]),
            .root_in  (root_w[k]),
            .side_in  (sside_w[k]),
            .rem_out  (rem_w[k+1]),
            .root_out (root_w[k+1]),
            .side_out (sside_w[k+1])
         );
      end

      assign a_w[0] = VEC_W'(root_w[ROOT_W]);
      assign b_w[0] = VEC_W'(sside_w[ROOT_W].mag) << FRAC_BITS;
      assign acc_w[0] = '0;
      assign cside_w[0] = sside_w[ROOT_W];

      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
         att_cordic_cell #(.STEP_IDX(s)) u_cell (
            .clock    (clock),
            .enable   (enable),
            .a_in     (a_w[s]),
            .b_in     (b_w[s]),
            .acc_in   (acc_w[s]),
            .side_in  (cside_w[s]),
            .a_out    (a_w[s+1]),
            .b_out    (b_w[s+1]),
            .acc_out  (acc_w[s+1]),
            .side_out (cside_w[s+1])
         );
      end

      // round half up to hundredths, clamp to 0..9000, apply zero cases, then sign
      always_comb begin
         acc_rnd = (acc_w[CORDIC_STAGES] + ACC_W'(128)) >>> 8;
         rnd = acc_rnd[ANGLE_W:0];
         if (acc_w[CORDIC_STAGES] < 0) begin
            mag_ang = '0;
         end else if (rnd > QUARTER_TURN) begin
            mag_ang = QUARTER_TURN;
         end else begin
            mag_ang = rnd;
         end
         if (cside_w[CORDIC_STAGES].num_zero) begin
            mag_ang = '0;
         end else if (cside_w[CORDIC_STAGES].den_zero) begin
            mag_ang = QUARTER_TURN;
         end
         ang_in[ln] = cside_w[CORDIC_STAGES].neg ? ANGLE_W'(-mag_ang)
                                                 : ANGLE_W'(mag_ang);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ang_ff <= ang_in;
      end
   end

   assign rsp_chan.valid = vld_ff[NUM_STAGES-1];
   assign rsp_chan.pitch_angle = ang_ff[0];
   assign rsp_chan.roll_angle = ang_ff[1];

   // a waiting, untaken word must hold the input off
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while output stalled");

   // angles stay within a quarter turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pitch_angle <= 15'sd9000
         && rsp_chan.pitch_angle >= -15'sd9000
         && rsp_chan.roll_angle <= 15'sd9000 && rsp_chan.roll_angle >= -15'sd9000))
      else $error("angle out of range");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("output valid after reset");

endmodule
`default_nettype wire
